### rtl/iff_pkg.sv
// Shared types and constants for the integer field formatter.
// No dependencies; used by rtl/integer_field_formatter.sv.
package iff_pkg;

  localparam int unsigned MAX_FIELD = 60;
  localparam int unsigned NUM_DIGS  = 22;   // octal digits of a 64-bit value
  localparam int unsigned BCD_DIGS  = 20;   // decimal digits of a 64-bit value
  localparam int unsigned ARG_W     = 64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [1:0] LEN_SHORT = 2'd0;
  localparam logic [1:0] LEN_INT   = 2'd1;
  localparam logic [1:0] RSEL_OCT  = 2'd0;
  localparam logic [1:0] RSEL_DEC  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BCD,
    ST_SCAN,
    ST_SIZE,
    ST_START,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RAD_OCT,
    RAD_DEC,
    RAD_HEX
  } rad_t;

  // Field segments in output order.
  typedef enum logic [2:0] {
    SEG_LSP,
    SEG_SIGN,
    SEG_OCT,
    SEG_HEX,
    SEG_ZER,
    SEG_DIG,
    SEG_TSP,
    SEG_NONE
  } seg_t;

  // Lowest set bit of a segment mask, or SEG_NONE.
  function automatic seg_t first_seg(logic [6:0] mask);
    seg_t s;
    s = SEG_NONE;
    for (int i = 6; i >= 0; i--) begin
      if (mask[i]) s = seg_t'(3'(i));
    end
    return s;
  endfunction

endpackage

### rtl/integer_field_formatter.sv
// Integer field formatter top level: printf-style integer to ASCII text.
// Depends on rtl/iff_pkg.sv.
//
// Usage: a request on the input channel (in_valid, in_stall) carries one
// integer argument and its conversion settings. The block answers with the
// formatted text field, one ASCII character per transfer on the output
// channel (out_valid, out_stall); run_end marks the field's last character.
// A zero value with no digits, sign, prefix or width gives no characters.
//
// Timing: one request at a time; in_stall stays high from acceptance until
// the last character is taken. Decimal first runs a serial shift-and-add-3
// binary to BCD converter; octal and hex skip it. A leading-zero scan then
// drops the leading zero digits, the sizing states (ST_SIZE, ST_START)
// follow, and the characters go out one per cycle while the receiver does
// not stall, at most 62. No new request is taken until the sequencer has
// returned to idle after the last character.
//
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// field in flight. While the receiver holds out_stall, the current
// character and run_end hold and the sequencer waits.
module integer_field_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] arg_bits,
  input  logic        is_signed_conv,
  input  logic [1:0]  length_mode,
  input  logic [1:0]  radix_select,
  input  logic        upper_digits,
  input  logic        align_left,
  input  logic        plus_flag,
  input  logic        space_flag,
  input  logic        alt_flag,
  input  logic        zero_flag,
  input  logic [5:0]  min_field,
  input  logic [5:0]  min_digits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        run_end
);

  localparam int unsigned DIG_W = 4 * iff_pkg::NUM_DIGS;
  localparam int unsigned BCD_W = 4 * iff_pkg::BCD_DIGS;

  iff_pkg::state_t state, state_next;
  iff_pkg::seg_t   seg;

  // Request settings, held for the whole field.
  logic       neg, upper, left, plus_f, zflag, sign_len, oct_pre, hex_pre;
  logic [5:0] width, prec;

  // Conversion datapath.
  logic [63:0]      mag;
  logic [BCD_W-1:0] bcd;
  logic [DIG_W-1:0] digs;
  logic [5:0]       bit_cnt;
  logic [4:0]       ndig;

  // Emission counters.
  logic [5:0] spaces, zeros, cnt, remain;

  logic in_take, out_take;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // ---------------------------------------------------------------------
  // Argument cut and magnitude, taken at the request.
  // ---------------------------------------------------------------------
  logic [63:0] cut_val, mag_in;
  logic        neg_in;
  iff_pkg::rad_t rad_in;
  logic [DIG_W-1:0] oct_digs, hex_digs;
  logic [65:0] oct_ext;

  always_comb begin
    case (length_mode)
      iff_pkg::LEN_SHORT:
        cut_val = {{48{is_signed_conv & arg_bits[15]}}, arg_bits[15:0]};
      iff_pkg::LEN_INT:
        cut_val = {{32{is_signed_conv & arg_bits[31]}}, arg_bits[31:0]};
      default: cut_val = arg_bits;
    endcase
    neg_in = is_signed_conv & cut_val[63];
    mag_in = neg_in ? (64'd0 - cut_val) : cut_val;
  end

  always_comb begin
    unique case (radix_select)
      iff_pkg::RSEL_OCT: rad_in = iff_pkg::RAD_OCT;
      iff_pkg::RSEL_DEC: rad_in = iff_pkg::RAD_DEC;
      default:           rad_in = iff_pkg::RAD_HEX;
    endcase
  end

  // Octal and hex digits fall straight out of the bits.
  always_comb begin
    oct_ext  = {2'b00, mag_in};
    hex_digs = DIG_W'(mag_in);
    for (int i = 0; i < iff_pkg::NUM_DIGS; i++) begin
      oct_digs[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
    end
  end

  // ---------------------------------------------------------------------
  // BCD step: add 3 to each digit of five or more, then shift.
  // ---------------------------------------------------------------------
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_step;
  logic [63:0]      mag_step;

  always_comb begin
    for (int i = 0; i < iff_pkg::BCD_DIGS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3)
                                                  : bcd[4*i +: 4];
    end
    {bcd_step, mag_step} = {bcd_adj[BCD_W-2:0], mag, 1'b0};
  end

  // ---------------------------------------------------------------------
  // Field sizing: zero fill, padding and total length.
  // ---------------------------------------------------------------------
  logic [5:0] body1, zeros0, body, spaces0;
  logic [6:0] tot;

  always_comb begin
    body1   = {1'b0, ndig} + {5'd0, oct_pre};
    zeros0  = (prec > body1) ? (prec - body1) : 6'd0;
    body    = body1 + {5'd0, sign_len} + {4'd0, hex_pre, 1'b0};
    tot     = {1'b0, body} + {1'b0, zeros0};
    spaces0 = ({1'b0, width} > tot) ? 6'({1'b0, width} - tot) : 6'd0;
  end

  // ---------------------------------------------------------------------
  // Segment lengths and the next non-empty segment.
  // ---------------------------------------------------------------------
  logic [6:0]    nonempty, after_mask;
  iff_pkg::seg_t seg_first, seg_after;
  logic [5:0]    len_first, len_after;

  function automatic logic [5:0] seg_len(iff_pkg::seg_t s, logic lft, logic [5:0] sp,
                                         logic sg, logic op, logic hp,
                                         logic [5:0] zr, logic [4:0] nd);
    logic [5:0] l;
    unique case (s)
      iff_pkg::SEG_LSP:  l = lft ? 6'd0 : sp;
      iff_pkg::SEG_SIGN: l = {5'd0, sg};
      iff_pkg::SEG_OCT:  l = {5'd0, op};
      iff_pkg::SEG_HEX:  l = {4'd0, hp, 1'b0};
      iff_pkg::SEG_ZER:  l = zr;
      iff_pkg::SEG_DIG:  l = {1'b0, nd};
      iff_pkg::SEG_TSP:  l = lft ? sp : 6'd0;
      default:           l = 6'd0;
    endcase
    return l;
  endfunction

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      nonempty[i] = seg_len(iff_pkg::seg_t'(3'(i)), left, spaces, sign_len,
                            oct_pre, hex_pre, zeros, ndig) != 6'd0;
    end
    after_mask = nonempty & ~7'(({1'b0, 7'd1} << (4'({1'b0, seg}) + 4'd1)) - 8'd1);
    seg_first  = iff_pkg::first_seg(nonempty);
    seg_after  = iff_pkg::first_seg(after_mask);
    len_first  = seg_len(seg_first, left, spaces, sign_len, oct_pre, hex_pre,
                         zeros, ndig);
    len_after  = seg_len(seg_after, left, spaces, sign_len, oct_pre, hex_pre,
                         zeros, ndig);
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iff_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iff_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = (rad_in == iff_pkg::RAD_DEC) ? iff_pkg::ST_BCD : iff_pkg::ST_SCAN;
        end
      end
      iff_pkg::ST_BCD: begin
        if (bit_cnt == 6'd0) state_next = iff_pkg::ST_SCAN;
      end
      iff_pkg::ST_SCAN: begin
        if (ndig == 5'd0 || digs[DIG_W-1 -: 4] != 4'd0) state_next = iff_pkg::ST_SIZE;
      end
      iff_pkg::ST_SIZE: state_next = iff_pkg::ST_START;
      iff_pkg::ST_START: begin
        state_next = (remain == 6'd0) ? iff_pkg::ST_IDLE : iff_pkg::ST_EMIT;
      end
      iff_pkg::ST_EMIT: begin
        if (out_take && remain == 6'd1) state_next = iff_pkg::ST_IDLE;
      end
      default: state_next = iff_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state != iff_pkg::ST_IDLE);
    out_valid = (state == iff_pkg::ST_EMIT);
    run_end   = (remain == 6'd1);
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      iff_pkg::ST_IDLE: begin
        if (in_take) begin
          neg      <= neg_in;
          upper    <= upper_digits;
          left     <= align_left;
          plus_f   <= plus_flag;
          zflag    <= zero_flag;
          width    <= (min_field  > 6'(iff_pkg::MAX_FIELD)) ? 6'(iff_pkg::MAX_FIELD)
                                                            : min_field;
          prec     <= (min_digits > 6'(iff_pkg::MAX_FIELD)) ? 6'(iff_pkg::MAX_FIELD)
                                                            : min_digits;
          sign_len <= (rad_in == iff_pkg::RAD_DEC) & is_signed_conv
                      & (plus_flag | space_flag | neg_in);
          oct_pre  <= (rad_in == iff_pkg::RAD_OCT) & alt_flag;
          hex_pre  <= (rad_in == iff_pkg::RAD_HEX) & alt_flag & (mag_in != 64'd0);
          mag      <= mag_in;
          bcd      <= '0;
          bit_cnt  <= 6'd63;
          ndig     <= 5'(iff_pkg::NUM_DIGS);
          digs     <= (rad_in == iff_pkg::RAD_OCT) ? oct_digs : hex_digs;
        end
      end
      iff_pkg::ST_BCD: begin
        mag     <= mag_step;
        bcd     <= bcd_step;
        bit_cnt <= bit_cnt - 6'd1;
        if (bit_cnt == 6'd0) begin
          digs <= {8'd0, bcd_step};
        end
      end
      iff_pkg::ST_SCAN: begin
        // Drop leading zero digits, one per cycle.
        if (ndig != 5'd0 && digs[DIG_W-1 -: 4] == 4'd0) begin
          digs <= {digs[DIG_W-5:0], 4'd0};
          ndig <= ndig - 5'd1;
        end
      end
      iff_pkg::ST_SIZE: begin
        remain <= 6'(tot + {1'b0, spaces0});
        if (zflag && !left) begin
          zeros  <= zeros0 + spaces0;
          spaces <= 6'd0;
        end else begin
          zeros  <= zeros0;
          spaces <= spaces0;
        end
      end
      iff_pkg::ST_START: begin
        seg <= seg_first;
        cnt <= len_first;
      end
      iff_pkg::ST_EMIT: begin
        if (out_take) begin
          remain <= remain - 6'd1;
          if (seg == iff_pkg::SEG_DIG) begin
            digs <= {digs[DIG_W-5:0], 4'd0};
          end
          if (cnt == 6'd1) begin
            seg <= seg_after;
            cnt <= len_after;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Character of the current segment position.
  logic [3:0] top_dig;
  assign top_dig = digs[DIG_W-1 -: 4];

  always_comb begin
    unique case (seg)
      iff_pkg::SEG_SIGN: out_char = neg ? iff_pkg::CH_MINUS
                                        : (plus_f ? iff_pkg::CH_PLUS : iff_pkg::CH_SPACE);
      iff_pkg::SEG_OCT:  out_char = iff_pkg::CH_ZERO;
      iff_pkg::SEG_HEX:  out_char = (cnt == 6'd2) ? iff_pkg::CH_ZERO
                                    : (upper ? iff_pkg::CH_UX : iff_pkg::CH_LX);
      iff_pkg::SEG_ZER:  out_char = iff_pkg::CH_ZERO;
      iff_pkg::SEG_DIG: begin
        if (top_dig > 4'd9) begin
          out_char = (upper ? iff_pkg::CH_UA : iff_pkg::CH_LA) + {4'd0, top_dig} - 8'd10;
        end else begin
          out_char = iff_pkg::CH_ZERO + {4'd0, top_dig};
        end
      end
      default:           out_char = iff_pkg::CH_SPACE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_emit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == iff_pkg::ST_EMIT) |-> (cnt != 6'd0 && remain != 6'd0 && seg != iff_pkg::SEG_NONE))
    else $error("emitting with an empty segment or count");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_take && run_end) |=> (state == iff_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after last character");

  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    (state != iff_pkg::ST_IDLE) |-> (ndig <= 5'(iff_pkg::NUM_DIGS)))
    else $error("digit count out of range");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == iff_pkg::ST_BCD || state == iff_pkg::ST_SCAN))
    else $error("request did not start conversion");

  a_dig_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == iff_pkg::ST_EMIT && seg == iff_pkg::SEG_DIG && cnt == {1'b0, ndig})
      |-> (top_dig != 4'd0))
    else $error("leading digit is zero");

endmodule
